>>> src/hfl_pkg.sv
// ----------------------------------------------------------------------------
// hfl_pkg
// Shared types, sizes and codes of the HMM forward likelihood unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hfl_pkg;

  // Model dimensions
  localparam int NUM_STATES  = 8;
  localparam int NUM_STREAMS = 4;
  localparam int NUM_SYMBOLS = 4;

  localparam int STATE_W  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int STREAM_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int NUSE_W   = 4;

  localparam int TR_DEPTH = NUM_STATES * NUM_STATES;
  localparam int TR_AW    = $clog2(TR_DEPTH);
  localparam int EM_DEPTH = NUM_STATES * NUM_STREAMS * NUM_SYMBOLS;
  localparam int EM_AW    = $clog2(EM_DEPTH);

  // Arithmetic widths
  localparam int PROB_W  = 17;
  localparam int ALPHA_W = 32;
  localparam int QUOT_W  = 32;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 48 + STATE_W;
  localparam int SUM_W   = 32 + STATE_W;
  localparam int P_W     = $clog2(SUM_W);
  localparam int L2_W    = 24;
  localparam int MAG_W   = L2_W - 1;

  localparam logic [PROB_W-1:0]  ONE_Q16 = 17'd65536;
  localparam logic [ALPHA_W-1:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
  localparam logic signed [31:0] LL_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] LL_MAX  = 32'sh7FFF_FFFF;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_TRANS = 2'd0,
    MODE_EMIS  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_OBS   = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCALING = 1'b0,
    CFG_STATES  = 1'b1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EM_RD,
    ST_EM_MUL,
    ST_EM_ACC,
    ST_PI_MUL,
    ST_PI_FIN,
    ST_TR_RD,
    ST_TR_MUL,
    ST_TR_ACC,
    ST_SC_MUL,
    ST_SC_FIN,
    ST_LG_START,
    ST_LG_NORM,
    ST_LG_MUL,
    ST_LG_ACC,
    ST_LN_MUL,
    ST_LN_FIN,
    ST_OUT_PREP,
    ST_OUT_DIV,
    ST_OUT_PUSH
  } fsm_e;

  typedef struct packed {
    mode_e        mode;
    logic [2:0]   row_index;
    logic [2:0]   column_index;
    logic [1:0]   stream_index;
    logic [1:0]   symbol_value;
    logic [16:0]  probability;
    logic [7:0]   obs_symbols;
    logic         first_in_sequence;
    logic         last_in_sequence;
  } in_t;

  typedef struct packed {
    logic [2:0]         state_index;
    logic [31:0]        alpha_value;
    logic               last_alpha;
    logic signed [31:0] log_likelihood;
    logic               likelihood_valid;
    logic               zero_probability;
  } out_t;

  // Shift controls for the alpha cell chain
  typedef struct packed {
    logic prev_shift;
    logic new_shift;
  } cell_ctl_t;

  // Divider request
  typedef struct packed {
    logic               start;
    logic [ALPHA_W-1:0] dividend;
    logic [SUM_W-1:0]   divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> src/hfl_cell.sv
// ----------------------------------------------------------------------------
// hfl_cell
// One alpha cell: holds the previous and the new alpha of one state slot
// and passes both on to its neighbour when told to shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hfl_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hfl_pkg::cell_ctl_t            ctl_i,
  input  wire logic [hfl_pkg::ALPHA_W-1:0]   prev_i,
  input  wire logic [hfl_pkg::ALPHA_W-1:0]   new_i,
  output logic      [hfl_pkg::ALPHA_W-1:0]   prev_o,
  output logic      [hfl_pkg::ALPHA_W-1:0]   new_o
);

  logic [hfl_pkg::ALPHA_W-1:0] prev_q;
  logic [hfl_pkg::ALPHA_W-1:0] new_q;

  // previous row, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctl_i.prev_shift) begin
      prev_q <= prev_i;
    end
  end

  // row under construction
  always_ff @(posedge clk_i) begin
    if (ctl_i.new_shift) begin
      new_q <= new_i;
    end
  end

  assign prev_o = prev_q;
  assign new_o  = new_q;

endmodule

`default_nettype wire

>>> src/hfl_mul.sv
// ----------------------------------------------------------------------------
// hfl_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module hfl_mul (
  input  wire logic                         clk_i,
  input  wire logic [31:0]                  a_i,
  input  wire logic [31:0]                  b_i,
  output logic      [hfl_pkg::PROD_W-1:0]   p_o
);

  logic [hfl_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= hfl_pkg::PROD_W'(a_i) * hfl_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> src/hfl_div.sv
// ----------------------------------------------------------------------------
// hfl_div
// Bit-serial restoring divider: quotient = (dividend << 31) / divisor,
// one quotient bit per cycle, dividend never above divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module hfl_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hfl_pkg::div_req_t           req_i,
  output logic                             done_o,
  output logic      [hfl_pkg::QUOT_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(hfl_pkg::QUOT_W);

  logic [hfl_pkg::SUM_W:0]    r_q;
  logic [hfl_pkg::SUM_W-1:0]  d_q;
  logic [hfl_pkg::QUOT_W-1:0] q_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [hfl_pkg::SUM_W:0]    r_sh;
  logic [hfl_pkg::SUM_W:0]    r_nx;
  logic                       ge;

  // one restoring step; the first step carries weight 2^31 with no shift
  always_comb begin
    r_sh = (cnt_q == '0) ? r_q : {r_q[hfl_pkg::SUM_W-1:0], 1'b0};
    ge   = r_sh >= {1'b0, d_q};
    r_nx = ge ? (r_sh - {1'b0, d_q}) : r_sh;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(hfl_pkg::QUOT_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(hfl_pkg::QUOT_W - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= (hfl_pkg::SUM_W + 1)'(req_i.dividend);
      d_q <= req_i.divisor;
    end else if (busy_q) begin
      r_q <= r_nx;
      q_q <= {q_q[hfl_pkg::QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

`default_nettype wire

>>> src/hmm_forward_likelihood_unit.sv
// ----------------------------------------------------------------------------
// hmm_forward_likelihood_unit
// Fixed-point hidden Markov forward pass with optional row scaling.
// ----------------------------------------------------------------------------
// Table loads are taken while the sequencer is idle. An observation request is
// worked one at a time by a sequencer around a single shared 32x32 multiplier:
// per state the emission product takes a read, multiply and accumulate step
// per stream, and the transition sum takes a read, multiply and accumulate step
// per source state (8 per destination, unused ones masked) while the previous
// alpha row circulates through the cell chain. A log (normalising, then 16
// squarings) follows when scaling is on or the request closes a sequence, and
// the alpha sum is not zero; in scaled mode each result of a used state waits
// on the bit-serial divider unless the sum is zero. Results go out through a
// one-entry output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_forward_likelihood_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire hfl_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output hfl_pkg::out_t       out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [0:0]     cfg_index_i,
  input  wire logic [3:0]     cfg_data_i
);

  localparam int N   = hfl_pkg::NUM_STATES;
  localparam int SW  = hfl_pkg::STATE_W;
  localparam int AW  = hfl_pkg::ALPHA_W;

  hfl_pkg::fsm_e state_q, state_d;

  // configuration
  logic                       scaling_q;
  logic [hfl_pkg::NUSE_W-1:0] nuse_q;
  logic [hfl_pkg::NUSE_W-1:0] n_eff;

  // tables
  logic [hfl_pkg::PROB_W-1:0] tr_mem [hfl_pkg::TR_DEPTH];
  logic [hfl_pkg::PROB_W-1:0] em_mem [hfl_pkg::EM_DEPTH];
  logic [hfl_pkg::PROB_W-1:0] init_q [N];
  logic [hfl_pkg::PROB_W-1:0] tr_rd_q, em_rd_q;
  logic                       em_bad_q;
  logic [hfl_pkg::TR_AW-1:0]  tr_addr;
  logic [hfl_pkg::EM_AW-1:0]  em_addr;
  logic [1:0]                 obs_sym;

  // sequencing and datapath
  logic [7:0]                    obs_q;
  logic                          first_q, last_q;
  logic [SW-1:0]                 j_q, i_q;
  logic [hfl_pkg::STREAM_W-1:0]  s_q;
  logic [AW-1:0]                 x_q;
  logic [hfl_pkg::ACC_W-1:0]     acc_q;
  logic [hfl_pkg::SUM_W-1:0]     sum_q, norm_q;
  logic [hfl_pkg::P_W-1:0]       p_q;
  logic [31:0]                   m_q;
  logic signed [hfl_pkg::L2_W-1:0] l2_q;
  logic [3:0]                    k_q;
  logic signed [31:0]            logacc_q, ll_q;
  logic [AW-1:0]                 res_q;
  logic                          out_valid_q;
  hfl_pkg::out_t                 out_q;

  // shared units
  logic [31:0]                 mul_a, mul_b;
  logic [hfl_pkg::PROD_W-1:0]  prod;
  hfl_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [hfl_pkg::QUOT_W-1:0]  div_quot;

  // cell chain
  hfl_pkg::cell_ctl_t cell_ctl;
  logic [AW-1:0]      prev_link [N];
  logic [AW-1:0]      new_link  [N];
  logic [AW-1:0]      prev_tail, new_tail;

  // helpers
  logic                        in_fire, out_fire;
  logic                        j_used, i_used, j_last, i_last, s_last;
  logic                        sum_zero, need_div, push_ok;
  logic [hfl_pkg::PROB_W-1:0]  prob_sat;
  logic [AW-1:0]               acc_sat, alpha_raw, alpha_fin;
  logic [32:0]                 sq;
  logic                        l2_neg;
  logic [hfl_pkg::MAG_W-1:0]   l2_mag, ln_mag;
  logic signed [31:0]          ln_s;
  logic signed [33:0]          tot;
  logic signed [31:0]          tot_sat;

  // --------------------------------------------------------------------------
  // Handshakes and small decodes
  // --------------------------------------------------------------------------
  assign in_stall_o  = (state_q != hfl_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (nuse_q == '0) begin
      n_eff = hfl_pkg::NUSE_W'(1);
    end else if (int'(nuse_q) > N) begin
      n_eff = hfl_pkg::NUSE_W'(N);
    end else begin
      n_eff = nuse_q;
    end
  end

  assign j_used   = hfl_pkg::NUSE_W'(j_q) < n_eff;
  assign i_used   = hfl_pkg::NUSE_W'(i_q) < n_eff;
  assign j_last   = (j_q == SW'(N - 1));
  assign i_last   = (i_q == SW'(N - 1));
  assign s_last   = (s_q == hfl_pkg::STREAM_W'(hfl_pkg::NUM_STREAMS - 1));
  assign sum_zero = (sum_q == '0);
  assign need_div = scaling_q && !sum_zero && j_used;
  assign push_ok  = !j_used || !out_valid_q || !out_stall_i;

  assign prob_sat = (in_data_i.probability > hfl_pkg::ONE_Q16) ?
                    hfl_pkg::ONE_Q16 : in_data_i.probability;

  // symbol of the current stream; streams past the packed ones see zero
  assign obs_sym = 2'(obs_q >> {s_q, 1'b0});
  assign tr_addr = hfl_pkg::TR_AW'(int'(i_q) * N + int'(j_q));
  assign em_addr = hfl_pkg::EM_AW'((int'(j_q) * hfl_pkg::NUM_STREAMS + int'(s_q))
                                   * hfl_pkg::NUM_SYMBOLS + int'(obs_sym));

  // transition sum >> 16, saturated to one
  always_comb begin
    if (acc_q[hfl_pkg::ACC_W-1:16] > (hfl_pkg::ACC_W - 16)'(hfl_pkg::ONE_Q31)) begin
      acc_sat = hfl_pkg::ONE_Q31;
    end else begin
      acc_sat = acc_q[16 +: AW];
    end
  end

  assign alpha_raw = (state_q == hfl_pkg::ST_PI_FIN) ? prod[16 +: AW] : prod[31 +: AW];
  assign alpha_fin = j_used ? alpha_raw : '0;

  // log helpers
  assign sq     = prod[63:31];
  assign l2_neg = l2_q < 0;
  assign l2_mag = l2_neg ? hfl_pkg::MAG_W'(-l2_q) : hfl_pkg::MAG_W'(l2_q);
  assign ln_mag = prod[32 +: hfl_pkg::MAG_W];
  assign ln_s   = l2_neg ? -$signed(32'(ln_mag)) : $signed(32'(ln_mag));
  assign tot    = (first_q ? 34'sd0 : 34'(logacc_q)) + 34'(ln_s);

  always_comb begin
    if (tot > 34'(hfl_pkg::LL_MAX)) begin
      tot_sat = hfl_pkg::LL_MAX;
    end else if (tot < 34'(hfl_pkg::LL_MIN)) begin
      tot_sat = hfl_pkg::LL_MIN;
    end else begin
      tot_sat = 32'(tot);
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hfl_pkg::ST_IDLE: begin
        if (in_fire && in_data_i.mode == hfl_pkg::MODE_OBS) begin
          state_d = hfl_pkg::ST_EM_RD;
        end
      end
      hfl_pkg::ST_EM_RD:  state_d = hfl_pkg::ST_EM_MUL;
      hfl_pkg::ST_EM_MUL: state_d = hfl_pkg::ST_EM_ACC;
      hfl_pkg::ST_EM_ACC: begin
        if (s_last) begin
          state_d = first_q ? hfl_pkg::ST_PI_MUL : hfl_pkg::ST_TR_RD;
        end else begin
          state_d = hfl_pkg::ST_EM_RD;
        end
      end
      hfl_pkg::ST_PI_MUL: state_d = hfl_pkg::ST_PI_FIN;
      hfl_pkg::ST_TR_RD:  state_d = hfl_pkg::ST_TR_MUL;
      hfl_pkg::ST_TR_MUL: state_d = hfl_pkg::ST_TR_ACC;
      hfl_pkg::ST_TR_ACC: state_d = i_last ? hfl_pkg::ST_SC_MUL : hfl_pkg::ST_TR_RD;
      hfl_pkg::ST_SC_MUL: state_d = hfl_pkg::ST_SC_FIN;
      hfl_pkg::ST_PI_FIN,
      hfl_pkg::ST_SC_FIN: state_d = j_last ? hfl_pkg::ST_LG_START : hfl_pkg::ST_EM_RD;
      hfl_pkg::ST_LG_START: begin
        if ((scaling_q || last_q) && !sum_zero) begin
          state_d = hfl_pkg::ST_LG_NORM;
        end else begin
          state_d = hfl_pkg::ST_OUT_PREP;
        end
      end
      hfl_pkg::ST_LG_NORM: begin
        if (norm_q[hfl_pkg::SUM_W-1]) begin
          state_d = hfl_pkg::ST_LG_MUL;
        end
      end
      hfl_pkg::ST_LG_MUL: state_d = hfl_pkg::ST_LG_ACC;
      hfl_pkg::ST_LG_ACC: state_d = (k_q == '0) ? hfl_pkg::ST_LN_MUL : hfl_pkg::ST_LG_MUL;
      hfl_pkg::ST_LN_MUL: state_d = hfl_pkg::ST_LN_FIN;
      hfl_pkg::ST_LN_FIN: state_d = hfl_pkg::ST_OUT_PREP;
      hfl_pkg::ST_OUT_PREP: state_d = need_div ? hfl_pkg::ST_OUT_DIV : hfl_pkg::ST_OUT_PUSH;
      hfl_pkg::ST_OUT_DIV: begin
        if (div_done) begin
          state_d = hfl_pkg::ST_OUT_PUSH;
        end
      end
      hfl_pkg::ST_OUT_PUSH: begin
        if (push_ok) begin
          state_d = j_last ? hfl_pkg::ST_IDLE : hfl_pkg::ST_OUT_PREP;
        end
      end
      default: state_d = hfl_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs: multiplier operands, chain shifts, divider request
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    cell_ctl         = '0;
    prev_tail        = '0;
    new_tail         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = new_link[0];
    div_req.divisor  = sum_q;
    unique case (state_q)
      hfl_pkg::ST_EM_MUL: begin
        mul_a = x_q;
        mul_b = em_bad_q ? 32'd0 : 32'(em_rd_q);
      end
      hfl_pkg::ST_PI_MUL: begin
        mul_a = 32'(init_q[j_q]);
        mul_b = x_q;
      end
      hfl_pkg::ST_TR_MUL: begin
        mul_a = prev_link[0];
        mul_b = 32'(tr_rd_q);
      end
      hfl_pkg::ST_TR_ACC: begin
        // rotate the previous row one place
        cell_ctl.prev_shift = 1'b1;
        prev_tail           = prev_link[0];
      end
      hfl_pkg::ST_SC_MUL: begin
        mul_a = acc_sat;
        mul_b = x_q;
      end
      hfl_pkg::ST_PI_FIN,
      hfl_pkg::ST_SC_FIN: begin
        cell_ctl.new_shift = 1'b1;
        new_tail           = alpha_fin;
      end
      hfl_pkg::ST_LG_MUL: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      hfl_pkg::ST_LN_MUL: begin
        mul_a = 32'(l2_mag);
        mul_b = hfl_pkg::LN2_Q32;
      end
      hfl_pkg::ST_OUT_PREP: begin
        div_req.start = need_div;
      end
      hfl_pkg::ST_OUT_PUSH: begin
        // final alpha replaces the previous row, new row advances
        cell_ctl.prev_shift = push_ok;
        cell_ctl.new_shift  = push_ok;
        prev_tail           = res_q;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hfl_pkg::ST_IDLE;
      scaling_q   <= 1'b1;
      nuse_q      <= hfl_pkg::NUSE_W'(8);
      out_valid_q <= 1'b0;
      logacc_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (hfl_pkg::cfg_idx_e'(cfg_index_i))
          hfl_pkg::CFG_SCALING: scaling_q <= cfg_data_i[0];
          hfl_pkg::CFG_STATES:  nuse_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == hfl_pkg::ST_OUT_PUSH && push_ok && j_used) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      // log accumulator
      if (state_q == hfl_pkg::ST_LG_START && sum_zero && scaling_q) begin
        logacc_q <= hfl_pkg::LL_MIN;
      end else if (state_q == hfl_pkg::ST_LN_FIN && scaling_q) begin
        logacc_q <= tot_sat;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tables: written by load requests, read registered
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.mode == hfl_pkg::MODE_TRANS &&
        int'(in_data_i.row_index) < N && int'(in_data_i.column_index) < N) begin
      tr_mem[hfl_pkg::TR_AW'(int'(in_data_i.row_index) * N
                             + int'(in_data_i.column_index))] <= prob_sat;
    end
    tr_rd_q <= tr_mem[tr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.mode == hfl_pkg::MODE_EMIS &&
        int'(in_data_i.row_index) < N &&
        int'(in_data_i.stream_index) < hfl_pkg::NUM_STREAMS &&
        int'(in_data_i.symbol_value) < hfl_pkg::NUM_SYMBOLS) begin
      em_mem[hfl_pkg::EM_AW'((int'(in_data_i.row_index) * hfl_pkg::NUM_STREAMS
                              + int'(in_data_i.stream_index)) * hfl_pkg::NUM_SYMBOLS
                             + int'(in_data_i.symbol_value))] <= prob_sat;
    end
    em_rd_q  <= em_mem[em_addr];
    em_bad_q <= int'(obs_sym) >= hfl_pkg::NUM_SYMBOLS;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.mode == hfl_pkg::MODE_INIT && int'(in_data_i.row_index) < N) begin
      init_q[SW'(in_data_i.row_index)] <= prob_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      hfl_pkg::ST_IDLE: begin
        if (in_fire) begin
          obs_q   <= in_data_i.obs_symbols;
          first_q <= in_data_i.first_in_sequence;
          last_q  <= in_data_i.last_in_sequence;
          j_q     <= '0;
          s_q     <= '0;
          x_q     <= hfl_pkg::ONE_Q31;
          sum_q   <= '0;
        end
      end
      hfl_pkg::ST_EM_ACC: begin
        x_q <= prod[16 +: AW];
        s_q <= s_last ? '0 : s_q + 1'b1;
        i_q   <= '0;
        acc_q <= '0;
      end
      hfl_pkg::ST_TR_ACC: begin
        if (i_used) begin
          acc_q <= acc_q + hfl_pkg::ACC_W'(prod[47:0]);
        end
        i_q <= i_last ? '0 : i_q + 1'b1;
      end
      hfl_pkg::ST_PI_FIN,
      hfl_pkg::ST_SC_FIN: begin
        sum_q <= sum_q + hfl_pkg::SUM_W'(alpha_fin);
        j_q   <= j_last ? '0 : j_q + 1'b1;
        s_q   <= '0;
        x_q   <= hfl_pkg::ONE_Q31;
      end
      hfl_pkg::ST_LG_START: begin
        norm_q <= sum_q;
        p_q    <= hfl_pkg::P_W'(hfl_pkg::SUM_W - 1);
        j_q    <= '0;
        if (sum_zero) begin
          ll_q <= hfl_pkg::LL_MIN;
        end
      end
      hfl_pkg::ST_LG_NORM: begin
        if (norm_q[hfl_pkg::SUM_W-1]) begin
          m_q  <= norm_q[hfl_pkg::SUM_W-1 -: 32];
          l2_q <= hfl_pkg::L2_W'((int'(p_q) - 31) * 65536);
          k_q  <= 4'd15;
        end else begin
          norm_q <= {norm_q[hfl_pkg::SUM_W-2:0], 1'b0};
          p_q    <= p_q - 1'b1;
        end
      end
      hfl_pkg::ST_LG_ACC: begin
        // one fraction bit of log2 per squaring
        if (sq[32]) begin
          m_q  <= sq[32:1];
          l2_q <= l2_q + (hfl_pkg::L2_W'(1) << k_q);
        end else begin
          m_q <= sq[31:0];
        end
        k_q <= k_q - 1'b1;
      end
      hfl_pkg::ST_LN_FIN: begin
        ll_q <= scaling_q ? tot_sat : ln_s;
      end
      hfl_pkg::ST_OUT_PREP: begin
        res_q <= j_used ? new_link[0] : '0;
      end
      hfl_pkg::ST_OUT_DIV: begin
        if (div_done) begin
          res_q <= div_quot;
        end
      end
      hfl_pkg::ST_OUT_PUSH: begin
        if (push_ok) begin
          j_q <= j_last ? '0 : j_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == hfl_pkg::ST_OUT_PUSH && push_ok && j_used) begin
      out_q.state_index      <= 3'(j_q);
      out_q.alpha_value      <= res_q;
      out_q.last_alpha       <= (hfl_pkg::NUSE_W'(j_q) == n_eff - 1'b1);
      out_q.log_likelihood   <= ((hfl_pkg::NUSE_W'(j_q) == n_eff - 1'b1) && last_q) ?
                                ll_q : 32'sd0;
      out_q.likelihood_valid <= (hfl_pkg::NUSE_W'(j_q) == n_eff - 1'b1) && last_q;
      out_q.zero_probability <= sum_zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Units
  // --------------------------------------------------------------------------
  hfl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  hfl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // alpha cell chain, cell 0 is the head
  for (genvar c = 0; c < N; c++) begin : g_cell
    logic [AW-1:0] prev_in, new_in;
    if (c == N - 1) begin : g_tail
      assign prev_in = prev_tail;
      assign new_in  = new_tail;
    end else begin : g_body
      assign prev_in = prev_link[c+1];
      assign new_in  = new_link[c+1];
    end
    hfl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .prev_i (prev_in),
      .new_i  (new_in),
      .prev_o (prev_link[c]),
      .new_o  (new_link[c])
    );
  end

endmodule

`default_nettype wire

>>> sim/hmm_forward_likelihood_unit_tb.sv
// ----------------------------------------------------------------------------
// hmm_forward_likelihood_unit_tb
// Self-checking bench for the HMM forward likelihood unit. The tables are
// filled by load requests, then directed and random observation sequences are
// run under several scaling and state-count settings. Each observation is
// predicted in the bench and every alpha result is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_forward_likelihood_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hfl_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = CFG_SCALING;
  logic [3:0] cfg_data = '0;

  hmm_forward_likelihood_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Bench copy of the block's tables, alpha row and settings
  logic [16:0] trans_tab [TR_DEPTH];
  logic [16:0] emis_tab [EM_DEPTH];
  logic [16:0] init_tab [NUM_STATES];
  longint unsigned alpha_row [NUM_STATES];
  longint log_acc;
  bit scale_en;
  int unsigned states_cfg;

  in_t  request_q [$];
  out_t alpha_q [$];
  int mismatches;
  int checked;
  int obs_count;
  int load_count;
  bit quiet;
  int hold_cnt;
  longint cycles;

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // ln(v / 2^31) in Q16.16 via log2 by repeated squaring
  function automatic longint ln_alpha(longint unsigned v);
    int p;
    longint unsigned m;
    longint l2;
    longint unsigned mag;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    if (p >= 31) m = v >> (p - 31);
    else m = v << (31 - p);
    l2 = longint'(p - 31) * 65536;
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        l2 += longint'(1) << k;
      end
    end
    mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
    mag = (mag * 64'd2977044472) >> 32;
    return (l2 < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Apply one accepted request and queue the alphas it should produce
  task automatic forward_step(input in_t r);
    logic [16:0] p;
    int n;
    longint unsigned x, acc, sum;
    longint unsigned emis [NUM_STATES];
    longint unsigned nxt [NUM_STATES];
    longint ll;
    bit zero;
    out_t o;
    p = (r.probability > ONE_Q16) ? ONE_Q16 : r.probability;
    case (r.mode)
      MODE_TRANS: trans_tab[r.row_index * NUM_STATES + r.column_index] = p;
      MODE_EMIS: emis_tab[(r.row_index * NUM_STREAMS + r.stream_index) * NUM_SYMBOLS
                          + r.symbol_value] = p;
      MODE_INIT: init_tab[r.row_index] = p;
      default: begin
        n = (states_cfg < 1) ? 1 : (states_cfg > NUM_STATES) ? NUM_STATES : states_cfg;
        for (int i = 0; i < n; i++) begin
          x = ONE_Q31;
          for (int s = 0; s < NUM_STREAMS; s++)
            x = (x * emis_tab[(i * NUM_STREAMS + s) * NUM_SYMBOLS
                              + ((r.obs_symbols >> (2 * s)) & 2'b11)]) >> 16;
          emis[i] = x;
        end
        sum = 0;
        for (int j = 0; j < n; j++) begin
          if (r.first_in_sequence) begin
            nxt[j] = (longint'(init_tab[j]) * emis[j]) >> 16;
          end else begin
            acc = 0;
            for (int i = 0; i < n; i++)
              acc += alpha_row[i] * trans_tab[i * NUM_STATES + j];
            acc = acc >> 16;
            if (acc > ONE_Q31) acc = ONE_Q31;
            nxt[j] = (acc * emis[j]) >> 31;
          end
          sum += nxt[j];
        end
        zero = (sum == 0);
        ll = 0;
        if (scale_en) begin
          if (zero) begin
            log_acc = -64'sd2147483648;
          end else begin
            for (int j = 0; j < n; j++) nxt[j] = (nxt[j] << 31) / sum;
            log_acc = clamp_s32((r.first_in_sequence ? 0 : log_acc) + ln_alpha(sum));
          end
          ll = log_acc;
        end else if (r.last_in_sequence) begin
          ll = zero ? -64'sd2147483648 : clamp_s32(ln_alpha(sum));
        end
        for (int j = 0; j < NUM_STATES; j++) alpha_row[j] = (j < n) ? nxt[j] : 0;
        for (int j = 0; j < n; j++) begin
          o.state_index      = j[2:0];
          o.alpha_value      = nxt[j][31:0];
          o.last_alpha       = (j == n - 1);
          o.likelihood_valid = (j == n - 1) && r.last_in_sequence;
          o.log_likelihood   = o.likelihood_valid ? ll[31:0] : 32'sd0;
          o.zero_probability = zero;
          alpha_q.push_back(o);
        end
      end
    endcase
  endtask

  // Request driver: random gaps, none once the run goes quiet
  int gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        forward_step(in_data);
        if (in_data.mode == MODE_OBS) obs_count++;
        else load_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall generator
  int stall_left;
  always @(posedge clk_i) begin
    out_t e;
    bit bad;
    if (rst_ni) begin
      cycles++;
      if (out_valid && !out_stall) begin
        if (alpha_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: state %0d alpha %h", out_data.state_index,
                     out_data.alpha_value);
        end else begin
          e = alpha_q.pop_front();
          checked++;
          bad = (out_data.state_index !== e.state_index)
             || (out_data.alpha_value !== e.alpha_value)
             || (out_data.last_alpha !== e.last_alpha)
             || (out_data.log_likelihood !== e.log_likelihood)
             || (out_data.likelihood_valid !== e.likelihood_valid)
             || (out_data.zero_probability !== e.zero_probability);
          if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: exp st %0d a %h la %b ll %h lv %b z %b / got st %0d a %h la %b ll %h lv %b z %b",
                       checked, e.state_index, e.alpha_value, e.last_alpha,
                       e.log_likelihood, e.likelihood_valid, e.zero_probability,
                       out_data.state_index, out_data.alpha_value, out_data.last_alpha,
                       out_data.log_likelihood, out_data.likelihood_valid,
                       out_data.zero_probability);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("hmm_forward_likelihood_unit: mismatch");
      $finish;
    end
  end

  function automatic in_t load_req(mode_e m, int row, int col, int strm, int sym, int prob);
    in_t r;
    r = in_t'($urandom);
    r.obs_symbols = $urandom;
    r.mode = m;
    r.row_index = row;
    r.column_index = col;
    r.stream_index = strm;
    r.symbol_value = sym;
    r.probability = prob;
    return r;
  endfunction

  function automatic int rand_prob();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic in_t obs_req(bit first, bit last, int symbols);
    in_t r;
    r = in_t'({$urandom, $urandom});
    r.mode = MODE_OBS;
    r.obs_symbols = symbols;
    r.first_in_sequence = first;
    r.last_in_sequence = last;
    return r;
  endfunction

  task automatic add_sequence(int len);
    for (int k = 0; k < len; k++)
      request_q.push_back(obs_req(k == 0, k == len - 1, $urandom_range(0, 255)));
  endtask

  // Mostly well-formed sequences, some stray loads and broken sequences
  task automatic add_random(int count);
    int made, len;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          request_q.push_back(load_req(mode_e'($urandom_range(0, 2)), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom_range(0, 3),
                              $urandom_range(0, 3), rand_prob()));
          made++;
        end
        2: begin
          request_q.push_back(obs_req($urandom_range(0, 1), $urandom_range(0, 1),
                                      $urandom_range(0, 255)));
          made++;
        end
        default: begin
          len = $urandom_range(1, 6);
          add_sequence(len);
          made += len;
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || alpha_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_SCALING) scale_en = value[0];
    else states_cfg = value[3:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int scaling, int states, int count);
    wait_idle();
    write_reg(CFG_SCALING, scaling);
    write_reg(CFG_STATES, states);
    add_random(count);
  endtask

  initial begin
    scale_en = 1'b1;
    states_cfg = NUM_STATES;
    log_acc = 0;
    for (int j = 0; j < NUM_STATES; j++) alpha_row[j] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every table entry so no observation reads an unwritten one
    for (int i = 0; i < NUM_STATES; i++)
      request_q.push_back(load_req(MODE_INIT, i, 0, 0, 0, rand_prob()));
    for (int i = 0; i < TR_DEPTH; i++)
      request_q.push_back(load_req(MODE_TRANS, i / 8, i % 8, 0, 0, rand_prob()));
    for (int i = 0; i < EM_DEPTH; i++)
      request_q.push_back(load_req(MODE_EMIS, i / 16, 0, (i / 4) % 4, i % 4,
                                   $urandom_range(20000, 131071)));

    // Directed: observation before any sequence, extremes, saturation, zero sum
    request_q.push_back(obs_req(1'b0, 1'b0, 8'h00));
    request_q.push_back(obs_req(1'b1, 1'b0, 8'hFF));
    request_q.push_back(obs_req(1'b0, 1'b1, 8'hE4));
    request_q.push_back(load_req(MODE_INIT, 7, 0, 0, 0, 131071));
    request_q.push_back(load_req(MODE_TRANS, 7, 7, 3, 3, 65536));
    request_q.push_back(obs_req(1'b1, 1'b1, 8'h1B));
    for (int i = 0; i < NUM_STATES; i++)
      request_q.push_back(load_req(MODE_EMIS, i, 0, 0, 3, 0));
    request_q.push_back(obs_req(1'b1, 1'b0, 8'h03));
    request_q.push_back(obs_req(1'b0, 1'b1, 8'h03));
    for (int i = 0; i < NUM_STATES; i++)
      request_q.push_back(load_req(MODE_EMIS, i, 0, 0, 3, $urandom_range(30000, 65536)));

    // Long receiver hold while requests keep coming
    run_phase(1, 8, 30);
    @(negedge clk_i);
    hold_cnt = 3000;
    run_phase(0, 8, 30);
    run_phase(1, 1, 25);
    run_phase(0, 0, 20);
    run_phase(1, 15, 25);
    run_phase(0, 3, 25);
    run_phase(1, 5, 25);
    wait_idle();
    quiet = 1'b1;
    run_phase(1, 8, 25);

    wait_idle();
    repeat (1000) @(posedge clk_i);
    $display("ran %0d observations and %0d table loads over eight settings", obs_count,
             load_count);
    $display("checked %0d alpha results, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && alpha_q.size() == 0)
      $display("hmm_forward_likelihood_unit: match");
    else
      $display("hmm_forward_likelihood_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/hfl_pkg.sv
src/hfl_cell.sv
src/hfl_mul.sv
src/hfl_div.sv
src/hmm_forward_likelihood_unit.sv
sim/hmm_forward_likelihood_unit_tb.sv
